FILE: src/nnd_pkg.sv
`default_nettype none

package nnd_pkg;

    // field and dimension widths
    localparam int PixW    = 8;
    localparam int DimW    = 13;
    localparam int MaxDim  = 4096;
    localparam int CfgIdxW = 3;

    // divider runs one quotient bit per cycle
    localparam int DivSteps = DimW;
    localparam int DivCntW  = $clog2(DivSteps);

    // register indexes on the configuration port
    typedef enum logic [CfgIdxW-1:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_DST_WIDTH  = 3'd2,
        REG_DST_HEIGHT = 3'd3,
        REG_ALPHA_EN   = 3'd4
    } reg_idx_t;

    // controller states
    typedef enum logic [2:0] {
        ST_LOAD_COL,
        ST_DIV_COL,
        ST_STORE_COL,
        ST_LOAD_ROW,
        ST_DIV_ROW,
        ST_STORE_ROW,
        ST_RUN
    } ctl_state_t;

    // controller to datapath
    typedef struct packed {
        logic div_load;
        logic div_step;
        logic div_store;
        logic sel_row;
        logic run;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cfg_hit;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: src/nnd_ctrl.sv
`default_nettype none

module nnd_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  nnd_pkg::dp_status_t status,
    output nnd_pkg::ctl_cmd_t   cmd
);

    nnd_pkg::ctl_state_t                 state_reg, state_next;
    logic [nnd_pkg::DivCntW-1:0]         cnt_reg, cnt_next;

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nnd_pkg::ST_LOAD_COL;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            nnd_pkg::ST_LOAD_COL:
            begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = nnd_pkg::ST_DIV_COL;
            end
            nnd_pkg::ST_DIV_COL:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == nnd_pkg::DivCntW'(nnd_pkg::DivSteps - 1))
                begin
                    cnt_next   = '0;
                    state_next = nnd_pkg::ST_STORE_COL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            nnd_pkg::ST_STORE_COL:
            begin
                cmd.div_store = 1'b1;
                state_next    = nnd_pkg::ST_LOAD_ROW;
            end
            nnd_pkg::ST_LOAD_ROW:
            begin
                cmd.sel_row  = 1'b1;
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = nnd_pkg::ST_DIV_ROW;
            end
            nnd_pkg::ST_DIV_ROW:
            begin
                cmd.sel_row  = 1'b1;
                cmd.div_step = 1'b1;
                if (cnt_reg == nnd_pkg::DivCntW'(nnd_pkg::DivSteps - 1))
                begin
                    cnt_next   = '0;
                    state_next = nnd_pkg::ST_STORE_ROW;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            nnd_pkg::ST_STORE_ROW:
            begin
                cmd.sel_row   = 1'b1;
                cmd.div_store = 1'b1;
                state_next    = nnd_pkg::ST_RUN;
            end
            nnd_pkg::ST_RUN:
            begin
                cmd.run = 1'b1;
            end
            default:
            begin
                state_next = nnd_pkg::ST_LOAD_COL;
            end
        endcase

        // a write to any listed register recomputes the step sizes
        if (status.cfg_hit)
        begin
            state_next = nnd_pkg::ST_LOAD_COL;
            cnt_next   = '0;
        end
    end

endmodule

`default_nettype wire

FILE: src/nnd_datapath.sv
`default_nettype none

module nnd_datapath (
    input  wire                              clk,
    input  wire                              rst_n,
    input  nnd_pkg::ctl_cmd_t                cmd,
    output nnd_pkg::dp_status_t              status,
    input  wire                              cfg_we,
    input  wire  [nnd_pkg::CfgIdxW-1:0]      cfg_index,
    input  wire  [nnd_pkg::DimW-1:0]         cfg_data,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [4*nnd_pkg::PixW-1:0]       s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [4*nnd_pkg::PixW-1:0]       m_axis_tdata,
    output logic                             m_axis_tlast,
    output logic                             m_axis_tuser
);

    localparam int W = nnd_pkg::DimW;
    localparam int P = nnd_pkg::PixW;

    // configuration registers
    logic [W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic         alpha_en_reg;

    // effective (clamped) dimensions
    logic [W-1:0] sw, sh, dw, dh;

    // divider
    logic [W-1:0] div_rem_reg, div_quo_reg, div_den_reg;
    logic [W:0]   div_trial;
    logic         div_bit;

    // step sizes: integer and fractional parts of src/dst
    logic [W-1:0] col_quo_reg, col_rem_reg, row_quo_reg, row_rem_reg;

    // frame position
    logic [W-1:0] sx_reg, sy_reg, ox_reg, oy_reg, tx_reg, ty_reg, fx_reg, fy_reg;

    // output register
    logic         out_valid_reg;
    logic [P-1:0] out_r_reg, out_g_reg, out_b_reg, out_a_reg;
    logic         out_row_end_reg, out_frame_end_reg;

    logic         in_accept, hit, last_col, last_row, src_last_col, src_last_row;
    logic [W:0]   fx_sum, fy_sum, tx_sum, ty_sum;
    logic         fx_wrap, fy_wrap;

    function automatic logic [W-1:0] clamp_dim(input logic [W-1:0] v,
                                               input logic [W-1:0] hi);
        logic [W-1:0] r;
        begin
            r = v;
            if (v == '0)
                r = W'(1);
            else if (v > hi)
                r = hi;
            return r;
        end
    endfunction

    assign sw = clamp_dim(src_w_reg, W'(nnd_pkg::MaxDim));
    assign sh = clamp_dim(src_h_reg, W'(nnd_pkg::MaxDim));
    assign dw = clamp_dim(dst_w_reg, sw);
    assign dh = clamp_dim(dst_h_reg, sh);

    // a write to a listed register restarts the frame
    always_comb
    begin
        case (cfg_index)
            nnd_pkg::REG_SRC_WIDTH,
            nnd_pkg::REG_SRC_HEIGHT,
            nnd_pkg::REG_DST_WIDTH,
            nnd_pkg::REG_DST_HEIGHT,
            nnd_pkg::REG_ALPHA_EN:   status.cfg_hit = cfg_we;
            default:                 status.cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg    <= W'(1);
            src_h_reg    <= W'(1);
            dst_w_reg    <= W'(1);
            dst_h_reg    <= W'(1);
            alpha_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nnd_pkg::REG_SRC_WIDTH:  src_w_reg    <= cfg_data;
                nnd_pkg::REG_SRC_HEIGHT: src_h_reg    <= cfg_data;
                nnd_pkg::REG_DST_WIDTH:  dst_w_reg    <= cfg_data;
                nnd_pkg::REG_DST_HEIGHT: dst_h_reg    <= cfg_data;
                nnd_pkg::REG_ALPHA_EN:   alpha_en_reg <= cfg_data[0];
                default:                 alpha_en_reg <= alpha_en_reg;
            endcase
        end
    end

    // restoring divider, one quotient bit per step
    assign div_trial = {div_rem_reg, div_quo_reg[W-1]};
    assign div_bit   = div_trial >= {1'b0, div_den_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= cmd.sel_row ? sh : sw;
            div_den_reg <= cmd.sel_row ? dh : dw;
        end
        else if (cmd.div_step)
        begin
            div_rem_reg <= div_bit ? W'(div_trial - {1'b0, div_den_reg})
                                   : W'(div_trial);
            div_quo_reg <= {div_quo_reg[W-2:0], div_bit};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_store)
        begin
            if (cmd.sel_row)
            begin
                row_quo_reg <= div_quo_reg;
                row_rem_reg <= div_rem_reg;
            end
            else
            begin
                col_quo_reg <= div_quo_reg;
                col_rem_reg <= div_rem_reg;
            end
        end
    end

    // input handshake and selection
    assign s_axis_tready = cmd.run && (!out_valid_reg || m_axis_tready);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign hit           = (sx_reg == tx_reg) && (sy_reg == ty_reg);
    assign last_col      = ({1'b0, ox_reg} + 1'b1) >= {1'b0, dw};
    assign last_row      = ({1'b0, oy_reg} + 1'b1) >= {1'b0, dh};
    assign src_last_col  = ({1'b0, sx_reg} + 1'b1) >= {1'b0, sw};
    assign src_last_row  = ({1'b0, sy_reg} + 1'b1) >= {1'b0, sh};

    // incremental target stepping: target += quo, frac += rem mod dst
    assign fx_sum  = {1'b0, fx_reg} + {1'b0, col_rem_reg};
    assign fx_wrap = fx_sum >= {1'b0, dw};
    assign tx_sum  = {1'b0, tx_reg} + {1'b0, col_quo_reg} + {{W{1'b0}}, fx_wrap};
    assign fy_sum  = {1'b0, fy_reg} + {1'b0, row_rem_reg};
    assign fy_wrap = fy_sum >= {1'b0, dh};
    assign ty_sum  = {1'b0, ty_reg} + {1'b0, row_quo_reg} + {{W{1'b0}}, fy_wrap};

    // frame position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg <= '0;
            sy_reg <= '0;
            ox_reg <= '0;
            oy_reg <= '0;
            tx_reg <= '0;
            ty_reg <= '0;
            fx_reg <= '0;
            fy_reg <= '0;
        end
        else if (status.cfg_hit)
        begin
            sx_reg <= '0;
            sy_reg <= '0;
            ox_reg <= '0;
            oy_reg <= '0;
            tx_reg <= '0;
            ty_reg <= '0;
            fx_reg <= '0;
            fy_reg <= '0;
        end
        else if (in_accept)
        begin
            // source raster position
            if (src_last_col)
            begin
                sx_reg <= '0;
                sy_reg <= src_last_row ? '0 : W'(sy_reg + 1'b1);
            end
            else
            begin
                sx_reg <= W'(sx_reg + 1'b1);
            end

            // output position and the source pixel it needs
            if (hit)
            begin
                if (last_col)
                begin
                    ox_reg <= '0;
                    tx_reg <= '0;
                    fx_reg <= '0;
                    if (last_row)
                    begin
                        oy_reg <= '0;
                        ty_reg <= '0;
                        fy_reg <= '0;
                    end
                    else
                    begin
                        oy_reg <= W'(oy_reg + 1'b1);
                        ty_reg <= W'(ty_sum);
                        fy_reg <= fy_wrap ? W'(fy_sum - {1'b0, dh}) : W'(fy_sum);
                    end
                end
                else
                begin
                    ox_reg <= W'(ox_reg + 1'b1);
                    tx_reg <= W'(tx_sum);
                    fx_reg <= fx_wrap ? W'(fx_sum - {1'b0, dw}) : W'(fx_sum);
                end
            end
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept && hit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && hit)
        begin
            out_r_reg         <= s_axis_tdata[P-1:0];
            out_g_reg         <= s_axis_tdata[2*P-1:P];
            out_b_reg         <= s_axis_tdata[3*P-1:2*P];
            out_a_reg         <= alpha_en_reg ? s_axis_tdata[4*P-1:3*P] : '0;
            out_row_end_reg   <= last_col;
            out_frame_end_reg <= last_col && last_row;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_a_reg, out_b_reg, out_g_reg, out_r_reg};
    assign m_axis_tlast  = out_row_end_reg;
    assign m_axis_tuser  = out_frame_end_reg;

endmodule

`default_nettype wire

FILE: src/nearest_neighbor_downscaler.sv
// A selected source pixel appears on the output in the cycle after it is taken.
// Throughput: one source pixel per cycle; a one-word output register decouples
// the sides, so input stalls while that word waits on m_axis_tready and during setup.
// After reset and after every register write, a setup (two 13-step serial
// divisions of source by target size) runs with s_axis_tready low.
// Reset: asynchronous, active low; sizes return to 1x1, RGB mode, frame at origin.
`default_nettype none

module nearest_neighbor_downscaler (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // configuration write port
    input  wire                                  cfg_we,
    input  wire  [nnd_pkg::CfgIdxW-1:0]          cfg_index,
    input  wire  [nnd_pkg::DimW-1:0]             cfg_data,
    // source pixels
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [4*nnd_pkg::PixW-1:0]           s_axis_tdata,  // in_red, in_green, in_blue, in_alpha
    // selected pixels
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [4*nnd_pkg::PixW-1:0]           m_axis_tdata,  // out_red, out_green, out_blue, out_alpha
    output logic                                 m_axis_tlast,  // row_end
    output logic                                 m_axis_tuser   // frame_end
);

    nnd_pkg::ctl_cmd_t   cmd;
    nnd_pkg::dp_status_t status;

    // setup sequencer
    nnd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // registers, divider, counters and output word
    nnd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire
